/* sv/brws_pkg.sv */
// ============================================================================
// brws_pkg
// Shared types and constants of the bounded request window scheduler.
// ============================================================================
`default_nettype none

package brws_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 32;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W       = 6;

    // Budget and window constants
    localparam logic [29:0] BYTES_MAX  = 30'h3FFF_FFFF;
    localparam logic [3:0]  WINDOW_CAP = 4'd8;

    // Register reset values
    localparam logic [3:0]  MAX_IN_FLIGHT_RST  = 4'd4;
    localparam logic [23:0] PER_ITEM_LIMIT_RST = 24'h10_0000;
    localparam logic [27:0] TOTAL_LIMIT_RST    = 28'h40_0000;

    // Register indexes
    localparam logic [1:0] REG_MAX_IN_FLIGHT  = 2'd0;
    localparam logic [1:0] REG_PER_ITEM_LIMIT = 2'd1;
    localparam logic [1:0] REG_TOTAL_LIMIT    = 2'd2;

    // Request function codes
    localparam logic [2:0] FN_REQUEST  = 3'd0;
    localparam logic [2:0] FN_COMPLETE = 3'd1;
    localparam logic [2:0] FN_QUERY    = 3'd2;
    localparam logic [2:0] FN_CLEAR    = 3'd3;
    localparam logic [2:0] FN_REFUSED  = 3'd4;

    // Entry states as stored
    localparam logic [1:0] ST_QUEUED = 2'd0;
    localparam logic [1:0] ST_FLIGHT = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;
    localparam logic [1:0] ST_FAILED = 2'd3;

    // Reported status codes
    localparam logic [2:0] RS_NOOP    = 3'd0;
    localparam logic [2:0] RS_FLIGHT  = 3'd2;
    localparam logic [2:0] RS_REFUSED = 3'd5;

    // Result kinds
    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_LAUNCH = 1'b1;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] key;
        logic [4:0]  entry_index;
        logic        success;
        logic [30:0] item_length;
    } req_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [4:0]  slot;
        logic [63:0] launch_key;
        logic [23:0] stored_length;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [63:0] key;
        logic [1:0]  state;
        logic [23:0] length;
    } entry_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch;
        logic clear;
        logic rd_ptr;
        logic rd_idx;
        logic rd_slot;
        logic lk_eval;
        logic append;
        logic cp_eval;
        logic fl_init;
        logic fl_eval;
        logic reply;
    } brws_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [2:0] func;
        logic       key_zero;
        logic       idx_ok;
        logic       match;
        logic       scan_end;
        logic       window_full;
        logic       slot_valid;
    } brws_stat_t;

endpackage

`default_nettype wire

/* sv/brws_ctrl.sv */
// ============================================================================
// brws_ctrl
// Sequencer: lookup, append, completion, fill pass and status reply.
// ============================================================================
`default_nettype none

module brws_ctrl
    import brws_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  brws_stat_t      stat,
    output brws_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_LK_RD, S_LK_EV, S_APPEND, S_CP_RD, S_CP_EV,
        S_FL_INIT, S_FL_RD, S_FL_EV, S_RP_RD, S_RP_EV
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.func == FN_REQUEST || stat.func == FN_QUERY)
                begin
                    state_next = stat.key_zero ? S_FL_INIT : S_LK_RD;
                end
                else if (stat.func == FN_COMPLETE || stat.func == FN_REFUSED)
                begin
                    state_next = stat.idx_ok ? S_CP_RD : S_FL_INIT;
                end
                else
                begin
                    cmd.clear  = (stat.func == FN_CLEAR);
                    state_next = S_FL_INIT;
                end
            end
            S_LK_RD:
            begin
                if (stat.scan_end)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    cmd.rd_ptr = 1'b1;
                    state_next = S_LK_EV;
                end
            end
            S_LK_EV:
            begin
                cmd.lk_eval = 1'b1;
                state_next  = stat.match ? S_FL_INIT : S_LK_RD;
            end
            S_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = S_FL_INIT;
            end
            S_CP_RD:
            begin
                cmd.rd_idx = 1'b1;
                state_next = S_CP_EV;
            end
            S_CP_EV:
            begin
                cmd.cp_eval = 1'b1;
                state_next  = S_FL_INIT;
            end
            S_FL_INIT:
            begin
                cmd.fl_init = 1'b1;
                state_next  = S_FL_RD;
            end
            S_FL_RD:
            begin
                if (stat.scan_end || stat.window_full)
                begin
                    state_next = S_RP_RD;
                end
                else
                begin
                    cmd.rd_ptr = 1'b1;
                    state_next = S_FL_EV;
                end
            end
            S_FL_EV:
            begin
                cmd.fl_eval = 1'b1;
                state_next  = S_FL_RD;
            end
            S_RP_RD:
            begin
                cmd.rd_slot = stat.slot_valid;
                state_next  = S_RP_EV;
            end
            S_RP_EV:
            begin
                cmd.reply  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

/* sv/brws_dp.sv */
// ============================================================================
// brws_dp
// Datapath: entry table memory, counters, byte budget and result register.
// ============================================================================
`default_nettype none

module brws_dp
    import brws_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  req_t             req,
    input  brws_cmd_t        cmd,
    output brws_stat_t       stat,
    input  wire logic [3:0]  max_in_flight,
    input  wire logic [23:0] per_item_limit,
    input  wire logic [27:0] total_limit,
    output rsp_t             rsp,
    output logic             rsp_strobe
);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    req_t             in_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] ptr_reg;
    logic [29:0]      bytes_reg;
    logic [3:0]       live_reg;
    logic [4:0]       slot_reg;
    logic             slot_valid_reg;
    logic             refused_reg;
    rsp_t             rsp_reg;
    logic             rsp_valid_reg;

    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;
    entry_t            wr_data;
    logic [3:0]        window;
    logic              over_budget;
    logic              table_full;
    logic              cp_fail;
    logic [30:0]       bytes_sum;
    logic [29:0]       bytes_new;

    // Status toward the controller
    assign window      = (max_in_flight > WINDOW_CAP) ? WINDOW_CAP : max_in_flight;
    assign over_budget = (bytes_reg >= 30'(total_limit));
    assign table_full  = (count_reg >= CNT_W'(TABLE_DEPTH));

    assign stat.func        = in_reg.func;
    assign stat.key_zero    = (in_reg.key == 64'd0);
    assign stat.idx_ok      = (CMP_W'(in_reg.entry_index) < CMP_W'(count_reg));
    assign stat.match       = (rd_data_reg.key == in_reg.key);
    assign stat.scan_end    = (ptr_reg >= count_reg);
    assign stat.window_full = (live_reg >= window);
    assign stat.slot_valid  = slot_valid_reg;

    // Completion decision and saturating byte sum
    assign cp_fail   = (in_reg.func == FN_REFUSED) || !in_reg.success
                       || (in_reg.item_length > 31'(per_item_limit));
    assign bytes_sum = 31'(bytes_reg) + 31'(in_reg.item_length[23:0]);
    assign bytes_new = (bytes_sum > 31'(BYTES_MAX)) ? BYTES_MAX : bytes_sum[29:0];

    // Memory read address
    always_comb
    begin
        rd_en   = cmd.rd_ptr || cmd.rd_idx || cmd.rd_slot;
        rd_addr = ptr_reg[ADDR_W-1:0];
        if (cmd.rd_idx)
        begin
            rd_addr = in_reg.entry_index[ADDR_W-1:0];
        end
        else if (cmd.rd_slot)
        begin
            rd_addr = slot_reg[ADDR_W-1:0];
        end
    end

    // Memory write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg[ADDR_W-1:0];
        wr_data = rd_data_reg;
        if (cmd.append && !table_full && !over_budget)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[ADDR_W-1:0];
            wr_data = '{key: in_reg.key, state: ST_QUEUED, length: 24'd0};
        end
        else if (cmd.cp_eval && rd_data_reg.state == ST_FLIGHT)
        begin
            wr_en   = 1'b1;
            wr_addr = in_reg.entry_index[ADDR_W-1:0];
            if (cp_fail)
            begin
                wr_data.state = ST_FAILED;
            end
            else
            begin
                wr_data.state  = ST_DONE;
                wr_data.length = in_reg.item_length[23:0];
            end
        end
        else if (cmd.fl_eval && rd_data_reg.state == ST_QUEUED)
        begin
            wr_en         = 1'b1;
            wr_data.state = over_budget ? ST_FAILED : ST_FLIGHT;
        end
    end

    // Entry table
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Latched request
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            in_reg <= req;
        end
    end

    // Table counters, budget and scan pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ptr_reg        <= '0;
            bytes_reg      <= '0;
            live_reg       <= '0;
            slot_reg       <= '0;
            slot_valid_reg <= 1'b0;
            refused_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.latch)
            begin
                ptr_reg        <= '0;
                slot_valid_reg <= 1'b0;
                refused_reg    <= 1'b0;
            end
            if (cmd.clear)
            begin
                count_reg <= '0;
                bytes_reg <= '0;
                live_reg  <= '0;
            end
            if (cmd.lk_eval)
            begin
                if (stat.match)
                begin
                    slot_reg       <= 5'(ptr_reg);
                    slot_valid_reg <= 1'b1;
                end
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (cmd.append)
            begin
                if (table_full || over_budget)
                begin
                    refused_reg <= 1'b1;
                end
                else
                begin
                    slot_reg       <= 5'(count_reg);
                    slot_valid_reg <= 1'b1;
                    count_reg      <= count_reg + 1'b1;
                end
            end
            if (cmd.cp_eval)
            begin
                slot_reg       <= in_reg.entry_index;
                slot_valid_reg <= 1'b1;
                if (rd_data_reg.state == ST_FLIGHT)
                begin
                    live_reg <= live_reg - 1'b1;
                    if (!cp_fail)
                    begin
                        bytes_reg <= bytes_new;
                    end
                end
            end
            if (cmd.fl_init)
            begin
                ptr_reg <= '0;
            end
            if (cmd.fl_eval)
            begin
                ptr_reg <= ptr_reg + 1'b1;
                if (rd_data_reg.state == ST_QUEUED && !over_budget)
                begin
                    live_reg <= live_reg + 1'b1;
                end
            end
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= cmd.reply
                || (cmd.fl_eval && rd_data_reg.state == ST_QUEUED && !over_budget);
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.fl_eval)
        begin
            rsp_reg <= '{kind: KIND_LAUNCH, status: RS_FLIGHT, slot: 5'(ptr_reg),
                         launch_key: rd_data_reg.key, stored_length: 24'd0,
                         last: 1'b0};
        end
        else if (cmd.reply)
        begin
            if (slot_valid_reg)
            begin
                rsp_reg <= '{kind: KIND_REPLY,
                             status: 3'(rd_data_reg.state) + 3'd1,
                             slot: slot_reg, launch_key: rd_data_reg.key,
                             stored_length: (rd_data_reg.state == ST_DONE)
                                            ? rd_data_reg.length : 24'd0,
                             last: 1'b1};
            end
            else if (refused_reg)
            begin
                rsp_reg <= '{kind: KIND_REPLY, status: RS_REFUSED, slot: 5'd0,
                             launch_key: in_reg.key, stored_length: 24'd0,
                             last: 1'b1};
            end
            else if (in_reg.func == FN_COMPLETE || in_reg.func == FN_REFUSED)
            begin
                rsp_reg <= '{kind: KIND_REPLY, status: RS_NOOP,
                             slot: in_reg.entry_index, launch_key: 64'd0,
                             stored_length: 24'd0, last: 1'b1};
            end
            else
            begin
                rsp_reg <= '{kind: KIND_REPLY, status: RS_NOOP, slot: 5'd0,
                             launch_key: 64'd0, stored_length: 24'd0,
                             last: 1'b1};
            end
        end
    end

    assign rsp        = rsp_reg;
    assign rsp_strobe = rsp_valid_reg;

`ifndef ASSERT_OFF
    // The in-flight count never exceeds the largest window.
    a_live_cap: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= WINDOW_CAP)
        else $error("in-flight count above window cap");

    // The table never holds more entries than it has slots.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // Launch orders are never last; status replies always are.
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.last == (rsp_reg.kind == KIND_REPLY)))
        else $error("last flag does not match result kind");
`endif

endmodule

`default_nettype wire

/* sv/bounded_request_window_scheduler_top.sv */
// ============================================================================
// bounded_request_window_scheduler_top
// Deduplicating request table with a launch window and byte budget.
// ============================================================================
// A request is taken when start is high and busy is low; busy then stays high
// until its closing status reply has been issued. Results appear on rsp for
// one cycle each, marked by rsp_strobe, and cannot be held off: launch orders
// first, then one status reply with last set. While busy, the block runs a
// key lookup over the stored slots and a fill pass that visits slots in
// table order (each at most 32 slots). A lookup that ends without a match
// adds an end-of-table check and an append. A completion or refused launch
// reads and updates its slot before the fill pass. The entry table is read
// one slot at a time.
// ============================================================================
`default_nettype none

module bounded_request_window_scheduler_top
    import brws_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  req_t             req,
    output rsp_t             rsp,
    output logic             rsp_strobe,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [3:0]  max_in_flight_reg;
    logic [23:0] per_item_limit_reg;
    logic [27:0] total_limit_reg;
    logic        wr_access;
    brws_cmd_t   cmd;
    brws_stat_t  stat;

    assign pready    = 1'b1;
    assign wr_access = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_in_flight_reg  <= MAX_IN_FLIGHT_RST;
            per_item_limit_reg <= PER_ITEM_LIMIT_RST;
            total_limit_reg    <= TOTAL_LIMIT_RST;
        end
        else if (wr_access)
        begin
            if (paddr[3:2] == REG_MAX_IN_FLIGHT)
            begin
                max_in_flight_reg <= pwdata[3:0];
            end
            if (paddr[3:2] == REG_PER_ITEM_LIMIT)
            begin
                per_item_limit_reg <= pwdata[23:0];
            end
            if (paddr[3:2] == REG_TOTAL_LIMIT)
            begin
                total_limit_reg <= pwdata[27:0];
            end
        end
    end

    // Register read back
    always_comb
    begin
        prdata = 32'd0;
        if (paddr[3:2] == REG_MAX_IN_FLIGHT)
        begin
            prdata = 32'(max_in_flight_reg);
        end
        else if (paddr[3:2] == REG_PER_ITEM_LIMIT)
        begin
            prdata = 32'(per_item_limit_reg);
        end
        else if (paddr[3:2] == REG_TOTAL_LIMIT)
        begin
            prdata = 32'(total_limit_reg);
        end
    end

    brws_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    brws_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .cmd            (cmd),
        .stat           (stat),
        .max_in_flight  (max_in_flight_reg),
        .per_item_limit (per_item_limit_reg),
        .total_limit    (total_limit_reg),
        .rsp            (rsp),
        .rsp_strobe     (rsp_strobe)
    );

endmodule

`default_nettype wire

/* tb/brws_checker.sv */
// ============================================================================
// brws_checker
// Predicts the scheduler's launch orders and status replies and compares them.
// ============================================================================
// Every accepted request runs through a behavioral copy of the entry table.
// The launch orders and the closing status reply that follow are queued, and
// each result strobe is compared field by field with the oldest queued result.
// Register writes on the configuration port update the copy of the registers.
// ============================================================================
`default_nettype none

module brws_checker
    import brws_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  req_t             req,
    input  rsp_t             rsp,
    input  wire logic        rsp_strobe,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               fail_count,
    output int               pending_results
);

    // Predicted table contents and registers
    logic [63:0] tbl_key [TABLE_DEPTH];
    logic [1:0]  tbl_state [TABLE_DEPTH];
    logic [23:0] tbl_len [TABLE_DEPTH];
    int          tbl_count;
    logic [29:0] bytes_used;
    logic [3:0]  window_reg;
    logic [23:0] item_limit_reg;
    logic [27:0] budget_reg;
    rsp_t        expected_results[$];

    assign pending_results = expected_results.size();

    function automatic rsp_t make_result(logic k, logic [2:0] st, logic [4:0] sl,
                                         logic [63:0] ky, logic [23:0] ln,
                                         logic lst);
        rsp_t r;
        r.kind = k;
        r.status = st;
        r.slot = sl;
        r.launch_key = ky;
        r.stored_length = ln;
        r.last = lst;
        return r;
    endfunction

    // Apply one request to the table model and queue its results.
    task automatic schedule_request(req_t q);
        int          slot;
        int          live;
        int          win;
        bit          refused;
        bit          ranged;
        logic [29:0] room;
        slot = -1;
        refused = 0;
        ranged = 0;
        if (q.func == FN_REQUEST || q.func == FN_QUERY) begin
            if (q.key != 64'd0) begin
                for (int i = 0; i < tbl_count; i++)
                    if (slot < 0 && tbl_key[i] == q.key) slot = i;
                if (slot < 0) begin
                    if (tbl_count >= TABLE_DEPTH || {2'b00, bytes_used} >= {4'd0, budget_reg})
                        refused = 1;
                    else begin
                        slot = tbl_count;
                        tbl_key[slot] = q.key;
                        tbl_state[slot] = ST_QUEUED;
                        tbl_len[slot] = 24'd0;
                        tbl_count++;
                    end
                end
            end
        end
        else if (q.func == FN_COMPLETE || q.func == FN_REFUSED) begin
            if (int'(q.entry_index) < tbl_count) begin
                ranged = 1;
                slot = q.entry_index;
                if (tbl_state[slot] == ST_FLIGHT) begin
                    if (q.func == FN_REFUSED || !q.success
                        || q.item_length > {7'd0, item_limit_reg})
                        tbl_state[slot] = ST_FAILED;
                    else begin
                        room = BYTES_MAX - bytes_used;
                        tbl_state[slot] = ST_DONE;
                        tbl_len[slot] = q.item_length[23:0];
                        bytes_used = (q.item_length > {1'b0, room}) ? BYTES_MAX
                                     : bytes_used + q.item_length[29:0];
                    end
                end
            end
        end
        else if (q.func == FN_CLEAR) begin
            tbl_count = 0;
            bytes_used = '0;
        end
        // Fill pass: launch queued entries in table order, or fail them once the budget is spent.
        win = (window_reg > WINDOW_CAP) ? WINDOW_CAP : window_reg;
        live = 0;
        for (int i = 0; i < tbl_count; i++)
            if (tbl_state[i] == ST_FLIGHT) live++;
        for (int i = 0; i < tbl_count && live < win; i++) begin
            if (tbl_state[i] == ST_QUEUED) begin
                if ({2'b00, bytes_used} >= {4'd0, budget_reg})
                    tbl_state[i] = ST_FAILED;
                else begin
                    tbl_state[i] = ST_FLIGHT;
                    live++;
                    expected_results.push_back(make_result(KIND_LAUNCH, RS_FLIGHT, i[4:0],
                                                           tbl_key[i], 24'd0, 1'b0));
                end
            end
        end
        // Closing status reply.
        if (slot >= 0)
            expected_results.push_back(make_result(KIND_REPLY, {1'b0, tbl_state[slot]} + 3'd1,
                slot[4:0], tbl_key[slot],
                (tbl_state[slot] == ST_DONE) ? tbl_len[slot] : 24'd0, 1'b1));
        else if (refused)
            expected_results.push_back(make_result(KIND_REPLY, RS_REFUSED, 5'd0, q.key,
                                                   24'd0, 1'b1));
        else if ((q.func == FN_COMPLETE || q.func == FN_REFUSED) && !ranged)
            expected_results.push_back(make_result(KIND_REPLY, RS_NOOP, q.entry_index, 64'd0,
                                                   24'd0, 1'b1));
        else
            expected_results.push_back(make_result(KIND_REPLY, RS_NOOP, 5'd0, 64'd0,
                                                   24'd0, 1'b1));
    endtask

    // Track requests, register writes and results at each rising edge.
    always @(posedge clk or negedge rst_n) begin
        rsp_t e;
        if (!rst_n) begin
            tbl_count = 0;
            bytes_used = '0;
            window_reg = MAX_IN_FLIGHT_RST;
            item_limit_reg = PER_ITEM_LIMIT_RST;
            budget_reg = TOTAL_LIMIT_RST;
            expected_results.delete();
            fail_count = 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_MAX_IN_FLIGHT:  window_reg = pwdata[3:0];
                    REG_PER_ITEM_LIMIT: item_limit_reg = pwdata[23:0];
                    REG_TOTAL_LIMIT:    budget_reg = pwdata[27:0];
                    default: ;
                endcase
            end
            if (rsp_strobe) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: kind %0d status %0d slot %0d",
                           rsp.kind, rsp.status, rsp.slot);
                    fail_count++;
                end
                else begin
                    e = expected_results.pop_front();
                    if (rsp.kind !== e.kind) begin
                        $error("kind: expected %0d, got %0d", e.kind, rsp.kind);
                        fail_count++;
                    end
                    if (rsp.status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.slot !== e.slot) begin
                        $error("slot: expected %0d, got %0d", e.slot, rsp.slot);
                        fail_count++;
                    end
                    if (rsp.launch_key !== e.launch_key) begin
                        $error("launch_key: expected %h, got %h", e.launch_key,
                               rsp.launch_key);
                        fail_count++;
                    end
                    if (rsp.stored_length !== e.stored_length) begin
                        $error("stored_length: expected %0d, got %0d", e.stored_length,
                               rsp.stored_length);
                        fail_count++;
                    end
                    if (rsp.last !== e.last) begin
                        $error("last: expected %0d, got %0d", e.last, rsp.last);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                schedule_request(req);
            end
        end
    end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ============================================================================
// testbench
// Stimulus and verdict for the bounded request window scheduler.
// ============================================================================
// Directed requests cover zero keys, known keys, a full table, the budget,
// rejected and accepted completions, out-of-range slots, clear and unused
// function codes. Random phases then run mostly well-formed request, completion and
// query sequences under several register settings, with bursty starts.
// ============================================================================
`default_nettype none

module testbench;
    import brws_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 200;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        req;
    rsp_t        rsp;
    logic        rsp_strobe;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_results;
    int          idle_cycles;
    int          burst_left;
    logic [63:0] key_pool[$];
    int          known_slots;

    bounded_request_window_scheduler_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req), .rsp(rsp),
        .rsp_strobe(rsp_strobe), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    brws_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req), .rsp(rsp),
        .rsp_strobe(rsp_strobe), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .pready(pready), .fail_count(fail_count),
        .pending_results(pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: too long without any request or result accepted.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || rsp_strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Write one register through the configuration port.
    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Wait until every predicted result has arrived and the block is idle.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Issue one request, honoring the burst and gap pattern.
    task automatic send(logic [2:0] fn, logic [63:0] k, logic [4:0] idx, logic ok,
                        logic [30:0] len);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(0, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 8);
        end
        req <= '{func: fn, key: k, entry_index: idx, success: ok, item_length: len};
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        burst_left--;
    endtask

    // Random key, reused from a small pool a third of the time so duplicates occur.
    function automatic logic [63:0] pick_key();
        logic [63:0] k;
        if (key_pool.size() > 0 && $urandom_range(0, 2) == 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        k = {$urandom, $urandom};
        if ($urandom_range(0, 15) == 0)
            k = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0, $urandom};
        if (k == 64'd0)
            k = 64'd1;
        key_pool.push_back(k);
        return k;
    endfunction

    // One random phase of mostly well-formed traffic.
    task automatic random_phase(int count);
        int          sel;
        logic [30:0] len;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 99);
            len = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 300000));
            if (sel < 35)
                send(FN_REQUEST, pick_key(), '0, 1'b0, '0);
            else if (sel < 65)
                send(FN_COMPLETE, '0, 5'($urandom_range(0, known_slots)),
                     $urandom_range(0, 5) != 0, len);
            else if (sel < 78)
                send(FN_QUERY, ($urandom_range(0, 7) == 0) ? 64'd0 : pick_key(), '0, 1'b0, '0);
            else if (sel < 88)
                send(FN_REFUSED, {$urandom, $urandom}, 5'($urandom_range(0, 31)),
                     1'($urandom_range(0, 1)), 31'($urandom));
            else if (sel < 92)
            begin
                send(FN_CLEAR, '0, '0, 1'b0, '0);
                key_pool.delete();
            end
            else
                send(3'($urandom_range(5, 7)), {$urandom, $urandom}, 5'($urandom_range(0, 31)),
                     1'($urandom_range(0, 1)), 31'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        burst_left = 0;
        known_slots = 31;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero key, new keys, known key, completions of each kind.
        send(FN_REQUEST, 64'd0, '0, 1'b0, '0);
        send(FN_REQUEST, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, '0);
        send(FN_REQUEST, 64'h1, '0, 1'b0, '0);
        send(FN_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, '0);
        send(FN_QUERY, 64'h5555_AAAA_5555_AAAA, '0, 1'b0, '0);
        send(FN_COMPLETE, '0, 5'd0, 1'b1, 31'h0010_0000);
        send(FN_COMPLETE, '0, 5'd1, 1'b1, 31'h0010_0001);
        send(FN_COMPLETE, '0, 5'd2, 1'b0, 31'h7FFF_FFFF);
        send(FN_COMPLETE, '0, 5'd0, 1'b1, 31'd5);
        send(FN_REFUSED, '0, 5'd31, 1'b1, 31'd0);
        send(FN_QUERY, 64'd0, '0, 1'b0, '0);
        send(3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 1'b1, 31'h7FFF_FFFF);
        send(FN_CLEAR, '0, '0, 1'b0, '0);
        drain();

        // Directed: budget spent, then a full table with a closed window.
        write_reg(REG_TOTAL_LIMIT, 32'd0);
        write_reg(REG_MAX_IN_FLIGHT, 32'd0);
        send(FN_REQUEST, 64'h77, '0, 1'b0, '0);
        drain();
        write_reg(REG_TOTAL_LIMIT, 32'h0FFF_FFFF);
        write_reg(REG_PER_ITEM_LIMIT, 32'h00FF_FFFF);
        for (int i = 0; i < 33; i++)
            send(FN_REQUEST, 64'h1000 + i, '0, 1'b0, '0);
        drain();
        write_reg(REG_MAX_IN_FLIGHT, 32'd15);
        send(FN_QUERY, 64'h1000, '0, 1'b0, '0);
        for (int i = 0; i < 8; i++)
            send(FN_COMPLETE, '0, i[4:0], 1'b1, 31'h00FF_FFFF);
        send(FN_CLEAR, '0, '0, 1'b0, '0);
        drain();

        // Random phases under several register settings.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_MAX_IN_FLIGHT, 32'd4);
                         write_reg(REG_PER_ITEM_LIMIT, 32'h0010_0000);
                         write_reg(REG_TOTAL_LIMIT, 32'h0040_0000); end
                1: begin write_reg(REG_MAX_IN_FLIGHT, 32'd1);
                         write_reg(REG_PER_ITEM_LIMIT, 32'd0);
                         write_reg(REG_TOTAL_LIMIT, 32'd400000); end
                2: begin write_reg(REG_MAX_IN_FLIGHT, 32'd8);
                         write_reg(REG_PER_ITEM_LIMIT, 32'h00FF_FFFF);
                         write_reg(REG_TOTAL_LIMIT, 32'h0FFF_FFFF); end
                3: begin write_reg(REG_MAX_IN_FLIGHT, $urandom_range(9, 15));
                         write_reg(REG_PER_ITEM_LIMIT, $urandom_range(0, 24'hFF_FFFF));
                         write_reg(REG_TOTAL_LIMIT, $urandom_range(0, 2000000)); end
                default: begin write_reg(REG_MAX_IN_FLIGHT, $urandom_range(0, 3));
                         write_reg(REG_PER_ITEM_LIMIT, 32'd200000);
                         write_reg(REG_TOTAL_LIMIT, 32'd1000000); end
            endcase
            send(FN_CLEAR, '0, '0, 1'b0, '0);
            key_pool.delete();
            random_phase(28);
            drain();
        end

        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
